FILE: rtl/bgpl_pkg.sv
// ----------------------------------------------------------------------------
// bgpl_pkg
// Shared types and constants of the beat grid position lookup unit.
// ----------------------------------------------------------------------------
package bgpl_pkg;

	localparam int DEF_MAX_BEATS     = 1024;
	localparam int DEF_WALK_LIMIT    = 4;
	localparam int DEF_TIME_BITS     = 48;
	localparam int DEF_FRACTION_BITS = 16;

	localparam int ENTRY_IDX_BITS = 10;
	localparam int COUNT_BITS     = 11;

	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CHK0,
		ST_CHKN,
		ST_HINT,
		ST_WALK,
		ST_BIS,
		ST_BISC,
		ST_INTA,
		ST_INTB,
		ST_INTC,
		ST_PREP,
		ST_DIV,
		ST_FIN
	} state_t;

	typedef enum logic [1:0] {
		MD_BEFORE,
		MD_IN,
		MD_AFTER
	} mode_t;

endpackage

FILE: rtl/beat_grid_position_lookup_unit.sv
// ----------------------------------------------------------------------------
// beat_grid_position_lookup_unit
// Beat table with fractional beat position lookup.
// ----------------------------------------------------------------------------
// Items are issued with start while busy is low; opcode selects a table load
// (entry_index, entry_time) or a position query (query_time). Loads give no
// result. Each query gives one result, shown for one cycle with done high:
// beat_position (signed fixed point), bracket_index and grid_ok.
// beat_count is written through cfg_valid/cfg_data; cfg_ready is always high.
// Write it only while no query is outstanding.
// A two-item queue decouples intake from execution; busy rises when full.
// A query passes the queue and result registers, the edge checks, the hint
// walk (bounded by WALK_LIMIT), bisection, the interval reads, the serial
// divider (skipped on a flat interval) and the finish state. A short grid
// answers straight from the idle state; a load is written as it is taken.
// Items are handled one at a time in the back end.
// Reset clears the queue, count and hint; table contents stay undefined
// until loaded. The receiver cannot stall results.
// ----------------------------------------------------------------------------
module beat_grid_position_lookup_unit #(
	parameter int MAX_BEATS     = bgpl_pkg::DEF_MAX_BEATS,
	parameter int WALK_LIMIT    = bgpl_pkg::DEF_WALK_LIMIT,
	parameter int TIME_BITS     = bgpl_pkg::DEF_TIME_BITS,
	parameter int FRACTION_BITS = bgpl_pkg::DEF_FRACTION_BITS
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  logic                               opcode,
	input  logic [bgpl_pkg::ENTRY_IDX_BITS-1:0] entry_index,
	input  logic [TIME_BITS-1:0]               entry_time,
	input  logic [TIME_BITS-1:0]               query_time,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [bgpl_pkg::COUNT_BITS-1:0]     cfg_data,
	output logic                               done,
	output logic [TIME_BITS-1:0]               beat_position,
	output logic [bgpl_pkg::ENTRY_IDX_BITS-1:0] bracket_index,
	output logic                               grid_ok
);

	logic [bgpl_pkg::COUNT_BITS-1:0]     beat_count_q;
	logic                               q_valid;
	logic                               q_pop;
	logic                               q_opcode;
	logic [bgpl_pkg::ENTRY_IDX_BITS-1:0] q_index;
	logic [TIME_BITS-1:0]               q_time;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			beat_count_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			beat_count_q <= cfg_data;
		end
	end

	bgpl_front #(
		.TIME_BITS(TIME_BITS)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.opcode(opcode),
		.entry_index(entry_index),
		.entry_time(entry_time),
		.query_time(query_time),
		.q_valid(q_valid),
		.q_pop(q_pop),
		.q_opcode(q_opcode),
		.q_index(q_index),
		.q_time(q_time)
	);

	bgpl_back #(
		.MAX_BEATS(MAX_BEATS),
		.WALK_LIMIT(WALK_LIMIT),
		.TIME_BITS(TIME_BITS),
		.FRACTION_BITS(FRACTION_BITS)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.beat_count(beat_count_q),
		.q_valid(q_valid),
		.q_pop(q_pop),
		.q_opcode(q_opcode),
		.q_index(q_index),
		.q_time(q_time),
		.done(done),
		.beat_position(beat_position),
		.bracket_index(bracket_index),
		.grid_ok(grid_ok)
	);

endmodule

FILE: rtl/bgpl_front.sv
// ----------------------------------------------------------------------------
// bgpl_front
// Command intake: takes items and queues them for the back end (two deep).
// ----------------------------------------------------------------------------
module bgpl_front #(
	parameter int TIME_BITS = bgpl_pkg::DEF_TIME_BITS
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  logic                               opcode,
	input  logic [bgpl_pkg::ENTRY_IDX_BITS-1:0] entry_index,
	input  logic [TIME_BITS-1:0]               entry_time,
	input  logic [TIME_BITS-1:0]               query_time,
	output logic                               q_valid,
	input  logic                               q_pop,
	output logic                               q_opcode,
	output logic [bgpl_pkg::ENTRY_IDX_BITS-1:0] q_index,
	output logic [TIME_BITS-1:0]               q_time
);

	localparam int IW = 1 + bgpl_pkg::ENTRY_IDX_BITS + TIME_BITS;

	logic [IW-1:0] fifo_q [2];
	logic          wr_ptr_q;
	logic          rd_ptr_q;
	logic [1:0]    count_q;
	logic          push;
	logic [IW-1:0] push_data;

	assign busy    = (count_q == 2'd2);
	assign push    = start && !busy;
	assign q_valid = (count_q != 2'd0);

	always_comb begin
		push_data = {opcode, entry_index, (opcode == bgpl_pkg::OP_QUERY) ? query_time : entry_time};
	end

	assign {q_opcode, q_index, q_time} = fifo_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (q_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, q_pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

FILE: rtl/bgpl_back.sv
// ----------------------------------------------------------------------------
// bgpl_back
// Execution: beat table memory, hint walk, bisection, serial divide, result.
// ----------------------------------------------------------------------------
module bgpl_back #(
	parameter int MAX_BEATS     = bgpl_pkg::DEF_MAX_BEATS,
	parameter int WALK_LIMIT    = bgpl_pkg::DEF_WALK_LIMIT,
	parameter int TIME_BITS     = bgpl_pkg::DEF_TIME_BITS,
	parameter int FRACTION_BITS = bgpl_pkg::DEF_FRACTION_BITS
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic [bgpl_pkg::COUNT_BITS-1:0]     beat_count,
	input  logic                               q_valid,
	output logic                               q_pop,
	input  logic                               q_opcode,
	input  logic [bgpl_pkg::ENTRY_IDX_BITS-1:0] q_index,
	input  logic [TIME_BITS-1:0]               q_time,
	output logic                               done,
	output logic [TIME_BITS-1:0]               beat_position,
	output logic [bgpl_pkg::ENTRY_IDX_BITS-1:0] bracket_index,
	output logic                               grid_ok
);

	localparam int AW = (MAX_BEATS > 2) ? $clog2(MAX_BEATS) : 1;
	localparam int CW = $clog2(MAX_BEATS + 1);
	localparam int KW = $clog2(WALK_LIMIT + 2);
	localparam int QW = TIME_BITS + FRACTION_BITS;
	localparam int DW = $clog2(QW + 1);
	localparam int W  = QW + 1;

	bgpl_pkg::state_t state_q, state_d;
	bgpl_pkg::mode_t  mode_q;

	logic [TIME_BITS-1:0] mem [MAX_BEATS];
	logic [TIME_BITS-1:0] rdata_q;
	logic [AW-1:0]        rd_addr;
	logic                 we;

	logic [TIME_BITS-1:0] at_q;
	logic [TIME_BITS-1:0] b0_q;
	logic [TIME_BITS-1:0] b1_q;
	logic [AW-1:0]        lo_q;
	logic [AW-1:0]        hi_q;
	logic [AW-1:0]        mid_q;
	logic [AW-1:0]        base_idx_q;
	logic [KW-1:0]        k_q;
	logic [AW-1:0]        hint_q;
	logic                 hint_valid_q;
	logic [TIME_BITS-1:0] step_q;
	logic [TIME_BITS-1:0] rem_q;
	logic [QW-1:0]        div_q;
	logic [DW-1:0]        cnt_q;

	logic [CW-1:0]        n;
	logic [AW-1:0]        n_m1;
	logic [AW-1:0]        n_m2;
	logic                 short_grid;
	logic [TIME_BITS:0]   rem2;
	logic                 qbit;
	logic [TIME_BITS-1:0] mag;
	logic                 neg;
	logic [W-1:0]         s_base;
	logic [W-1:0]         sum_pos;
	logic [W-1:0]         q_neg;
	logic [W-1:0]         res;
	logic [TIME_BITS-1:0] zero_bias;

	assign zero_bias = {1'b1, {(TIME_BITS-1){1'b0}}};

	always_comb begin
		if (32'(beat_count) > 32'(MAX_BEATS)) begin
			n = CW'(MAX_BEATS);
		end else begin
			n = CW'(beat_count);
		end
		n_m1       = AW'(n - CW'(1));
		n_m2       = AW'(n - CW'(2));
		short_grid = (n < CW'(2));
	end

	assign q_pop = (state_q == bgpl_pkg::ST_IDLE) && q_valid;
	assign we    = q_pop && (q_opcode == bgpl_pkg::OP_LOAD) && (32'(q_index) < 32'(MAX_BEATS));

	always_ff @(posedge clk) begin
		if (we) begin
			mem[AW'(q_index)] <= {~q_time[TIME_BITS-1], q_time[TIME_BITS-2:0]};
		end
		rdata_q <= mem[rd_addr];
	end

	// divide step and final combine
	always_comb begin
		rem2 = {rem_q, div_q[QW-1]};
		qbit = (rem2 >= {1'b0, step_q});
		neg  = (mode_q == bgpl_pkg::MD_BEFORE);
		case (mode_q)
			bgpl_pkg::MD_BEFORE: mag = b0_q - at_q;
			bgpl_pkg::MD_AFTER:  mag = at_q - b1_q;
			default:             mag = at_q - b0_q;
		endcase
		s_base  = W'(zero_bias) + (W'(base_idx_q) << FRACTION_BITS);
		sum_pos = s_base + W'(div_q);
		q_neg   = W'(div_q) + W'(rem_q != '0);
		if (neg) begin
			res = (q_neg > s_base) ? '0 : s_base - q_neg;
		end else if (sum_pos > W'({TIME_BITS{1'b1}})) begin
			res = W'({TIME_BITS{1'b1}});
		end else begin
			res = sum_pos;
		end
	end

	always_comb begin
		state_d = state_q;
		rd_addr = '0;
		case (state_q)
			bgpl_pkg::ST_IDLE: begin
				if (q_pop && q_opcode == bgpl_pkg::OP_QUERY && !short_grid) begin
					state_d = bgpl_pkg::ST_CHK0;
				end
			end
			bgpl_pkg::ST_CHK0: begin
				if (at_q < rdata_q) begin
					state_d = bgpl_pkg::ST_INTA;
				end else begin
					rd_addr = n_m1;
					state_d = bgpl_pkg::ST_CHKN;
				end
			end
			bgpl_pkg::ST_CHKN: begin
				if (at_q >= rdata_q) begin
					state_d = bgpl_pkg::ST_INTA;
				end else if (hint_valid_q && hint_q <= n_m2) begin
					rd_addr = hint_q;
					state_d = bgpl_pkg::ST_HINT;
				end else begin
					state_d = bgpl_pkg::ST_BIS;
				end
			end
			bgpl_pkg::ST_HINT: begin
				if (rdata_q <= at_q) begin
					rd_addr = lo_q + AW'(1);
					state_d = bgpl_pkg::ST_WALK;
				end else begin
					state_d = bgpl_pkg::ST_BIS;
				end
			end
			bgpl_pkg::ST_WALK: begin
				if (at_q < rdata_q) begin
					state_d = bgpl_pkg::ST_INTA;
				end else if (k_q < KW'(WALK_LIMIT) && lo_q < n_m2) begin
					rd_addr = lo_q + AW'(2);
				end else begin
					state_d = bgpl_pkg::ST_BIS;
				end
			end
			bgpl_pkg::ST_BIS: begin
				if ((hi_q - lo_q) > AW'(1)) begin
					rd_addr = lo_q + ((hi_q - lo_q) >> 1);
					state_d = bgpl_pkg::ST_BISC;
				end else begin
					state_d = bgpl_pkg::ST_INTA;
				end
			end
			bgpl_pkg::ST_BISC: state_d = bgpl_pkg::ST_BIS;
			bgpl_pkg::ST_INTA: begin
				rd_addr = lo_q;
				state_d = bgpl_pkg::ST_INTB;
			end
			bgpl_pkg::ST_INTB: begin
				rd_addr = lo_q + AW'(1);
				state_d = bgpl_pkg::ST_INTC;
			end
			bgpl_pkg::ST_INTC: state_d = bgpl_pkg::ST_PREP;
			bgpl_pkg::ST_PREP: begin
				state_d = (b1_q <= b0_q) ? bgpl_pkg::ST_FIN : bgpl_pkg::ST_DIV;
			end
			bgpl_pkg::ST_DIV: begin
				if (cnt_q == DW'(1)) begin
					state_d = bgpl_pkg::ST_FIN;
				end
			end
			bgpl_pkg::ST_FIN: state_d = bgpl_pkg::ST_IDLE;
			default: state_d = bgpl_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= bgpl_pkg::ST_IDLE;
			hint_q       <= '0;
			hint_valid_q <= 1'b0;
			done         <= 1'b0;
		end else begin
			state_q <= state_d;
			done    <= 1'b0;
			if ((state_q == bgpl_pkg::ST_IDLE && q_pop && q_opcode == bgpl_pkg::OP_QUERY
					&& short_grid) || state_q == bgpl_pkg::ST_FIN) begin
				done <= 1'b1;
			end
			if (state_q == bgpl_pkg::ST_INTA && mode_q == bgpl_pkg::MD_IN) begin
				hint_q       <= lo_q;
				hint_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			bgpl_pkg::ST_IDLE: begin
				at_q          <= {~q_time[TIME_BITS-1], q_time[TIME_BITS-2:0]};
				beat_position <= '0;
				bracket_index <= '0;
				grid_ok       <= 1'b0;
			end
			bgpl_pkg::ST_CHK0: begin
				mode_q     <= bgpl_pkg::MD_BEFORE;
				lo_q       <= '0;
				base_idx_q <= '0;
			end
			bgpl_pkg::ST_CHKN: begin
				k_q <= '0;
				hi_q <= n_m1;
				if (at_q >= rdata_q) begin
					mode_q     <= bgpl_pkg::MD_AFTER;
					lo_q       <= n_m2;
					base_idx_q <= n_m1;
				end else begin
					mode_q <= bgpl_pkg::MD_IN;
					lo_q   <= hint_valid_q && hint_q <= n_m2 ? hint_q : '0;
				end
			end
			bgpl_pkg::ST_HINT: begin
				if (!(rdata_q <= at_q)) begin
					lo_q <= '0;
				end
			end
			bgpl_pkg::ST_WALK: begin
				if (!(at_q < rdata_q)) begin
					if (k_q < KW'(WALK_LIMIT) && lo_q < n_m2) begin
						lo_q <= lo_q + AW'(1);
						k_q  <= k_q + KW'(1);
					end else begin
						lo_q <= '0;
					end
				end
			end
			bgpl_pkg::ST_BIS: begin
				mid_q <= lo_q + ((hi_q - lo_q) >> 1);
			end
			bgpl_pkg::ST_BISC: begin
				if (rdata_q <= at_q) begin
					lo_q <= mid_q;
				end else begin
					hi_q <= mid_q;
				end
			end
			bgpl_pkg::ST_INTA: begin
				if (mode_q == bgpl_pkg::MD_IN) begin
					base_idx_q <= lo_q;
				end
			end
			bgpl_pkg::ST_INTB: b0_q <= rdata_q;
			bgpl_pkg::ST_INTC: b1_q <= rdata_q;
			bgpl_pkg::ST_PREP: begin
				step_q <= b1_q - b0_q;
				rem_q  <= '0;
				cnt_q  <= DW'(QW);
				if (b1_q <= b0_q) begin
					div_q <= '0;
				end else begin
					div_q <= {mag, {FRACTION_BITS{1'b0}}};
				end
			end
			bgpl_pkg::ST_DIV: begin
				rem_q <= qbit ? TIME_BITS'(rem2 - {1'b0, step_q}) : TIME_BITS'(rem2);
				div_q <= {div_q[QW-2:0], qbit};
				cnt_q <= cnt_q - DW'(1);
			end
			bgpl_pkg::ST_FIN: begin
				beat_position <= res[TIME_BITS-1:0] ^ zero_bias;
				bracket_index <= bgpl_pkg::ENTRY_IDX_BITS'(lo_q);
				grid_ok       <= 1'b1;
			end
			default: ;
		endcase
	end

	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> state_q == bgpl_pkg::ST_IDLE)
		else $error("item taken while busy");

	a_done_src: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q) == bgpl_pkg::ST_FIN || $past(state_q) == bgpl_pkg::ST_IDLE)
		else $error("result without finish");

	a_hint_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		hint_valid_q |=> hint_valid_q)
		else $error("hint lost");

	a_div_len: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == bgpl_pkg::ST_DIV |-> cnt_q != '0)
		else $error("divide count underrun");

endmodule
